// ===== rtl/ihtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed heap task queue package
// Shared widths, entry layout, codes, command/status bundles, ordering rule.
// ----------------------------------------------------------------------------
package ihtq_pkg;

    localparam int HEAP_DEPTH    = 256;
    localparam int TASK_ID_COUNT = 1024;
    localparam int SLOT_W        = $clog2(HEAP_DEPTH);
    localparam int CNT_W         = SLOT_W + 1;
    localparam int TASK_W        = $clog2(TASK_ID_COUNT);
    localparam int USER_W        = 16;
    localparam int PRIO_W        = 32;
    localparam int STATUS_W      = 3;
    localparam int KIND_W        = 2;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TASK_W-1:0] tid_t;

    typedef struct packed {
        logic [USER_W-1:0] user;
        tid_t              tid;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [KIND_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_EDIT   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_EXEC   = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_DUP     = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        RD_ZERO, RD_SLOT, RD_PARENT, RD_LEFT, RD_RIGHT, RD_LAST
    } rd_sel_t;

    typedef enum logic [2:0] {
        HO_KEEP, HO_CNT, HO_SLOT, HO_ZERO, HO_PARENT, HO_BEST
    } hole_op_t;

    typedef enum logic [1:0] {
        CO_KEEP, CO_REQ, CO_EDIT, CO_RD
    } cur_op_t;

    typedef enum logic [1:0] {
        HW_RD, HW_BEST, HW_CUR
    } heap_wsel_t;

    typedef enum logic [1:0] {
        PW_CLEAR, PW_INVAL_TOP, PW_INVAL_REQ, PW_MOVE
    } pos_wsel_t;

    typedef struct packed {
        logic       load_req;
        rd_sel_t    rd_sel;
        hole_op_t   hole_op;
        cur_op_t    cur_op;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       left_ld;
        logic       heap_we;
        heap_wsel_t heap_wsel;
        logic       pos_we;
        pos_wsel_t  pos_wsel;
        logic       clr_inc;
        logic       res_ld;
        status_t    res_status;
        logic       res_exec;
        logic       out_ld;
    } dp_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      pos_valid;
        logic      cnt_zero;
        logic      cnt_full;
        logic      hole_zero;
        logic      hole_is_last;
        logic      left_in;
        logic      cur_wins;
        logic      best_is_cur;
        logic      clr_done;
        logic      out_busy;
    } dp_stat_t;

    // Higher priority wins; ties go to the higher task id.
    function automatic logic outranks(entry_t a, entry_t b);
        if (a.prio != b.prio) begin
            return a.prio > b.prio;
        end
        return a.tid > b.tid;
    endfunction

endpackage

// ===== rtl/indexed_max_heap_task_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed max-heap task queue
// Binary max-heap of tasks with a task-id position map for in-place edits.
// ----------------------------------------------------------------------------
// Usage: each item is one request (add, edit priority, remove, execute top)
// and yields exactly one result item with a status and, for a successful
// execute top, the user and task id popped. Higher priority wins, equal
// priority goes to the higher task id. After reset the block clears the
// position map and takes no item until that is done. Items are handled
// one at a time. Every request passes through accept, decode and hand-off,
// and a rejected request or an execute top on an empty queue does nothing
// else. An edit, remove or execute top that moves an entry first reads it;
// each level moved up takes one parent read and compare, each level
// moved down a left and a right child read through the single heap read
// port, then a three-way compare, and the move ends with the closing check
// and a final write. The worst case is an execute top or remove that sinks
// the moved entry from the root to a leaf. Hand-off stalls while the
// previous result still waits for m_ready. The result register lets the
// next item be accepted while the previous result still waits for m_ready.
// ----------------------------------------------------------------------------
module indexed_max_heap_task_queue_unit
    import ihtq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [USER_W-1:0] s_user_id,
    input  logic [TASK_W-1:0] s_task_id,
    input  logic [PRIO_W-1:0] s_priority_req,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [USER_W-1:0] m_exec_user,
    output logic [TASK_W-1:0] m_exec_task
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Task ids are TASK_W bits wide and TASK_ID_COUNT is 2**TASK_W, so
    // every id falls inside the map.
    ihtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ihtq_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_user_id      (s_user_id),
        .s_task_id      (s_task_id),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_exec_user    (m_exec_user),
        .m_exec_task    (m_exec_task)
    );

endmodule

// ===== rtl/ihtq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed heap task queue datapath
// Heap and position memories, moving entry, hole index, count, result regs.
// ----------------------------------------------------------------------------
module ihtq_datapath
    import ihtq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [1:0]        s_req_type,
    input  logic [USER_W-1:0] s_user_id,
    input  tid_t              s_task_id,
    input  logic [PRIO_W-1:0] s_priority_req,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [USER_W-1:0] m_exec_user,
    output tid_t              m_exec_task
);

    entry_t            heap_mem [HEAP_DEPTH];
    logic [SLOT_W:0]   pos_mem  [TASK_ID_COUNT];

    entry_t            heap_rd_reg;
    logic [SLOT_W:0]   pos_rd_reg;

    req_kind_t         kind_reg;
    logic [USER_W-1:0] user_reg;
    tid_t              tid_reg;
    logic [PRIO_W-1:0] prio_reg;
    entry_t            cur_reg, cur_next;
    entry_t            left_reg;
    slot_t             hole_reg, hole_next;
    cnt_t              cnt_reg;
    tid_t              clr_reg;
    status_t           res_status_reg;
    logic [USER_W-1:0] res_user_reg;
    tid_t              res_task_reg;
    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [USER_W-1:0] m_user_reg;
    tid_t              m_task_reg;

    slot_t             parent;
    logic [SLOT_W:0]   l_idx;
    logic [SLOT_W+1:0] r_idx;
    logic              right_in, left_win, right_win;
    entry_t            best_l, best_e;
    slot_t             best_idx;
    slot_t             rd_addr;
    entry_t            heap_wdata;
    tid_t              pos_waddr;
    logic [SLOT_W:0]   pos_wdata;

    assign parent   = slot_t'(hole_reg - slot_t'(1)) >> 1;
    assign l_idx    = {hole_reg, 1'b1};
    assign r_idx    = {1'b0, hole_reg, 1'b0} + (SLOT_W+2)'(2);
    assign right_in = r_idx < {1'b0, cnt_reg};

    // Best of moving entry, left child (registered) and right child (just read).
    assign left_win  = outranks(left_reg, cur_reg);
    assign best_l    = left_win ? left_reg : cur_reg;
    assign right_win = right_in && outranks(heap_rd_reg, best_l);
    assign best_e    = right_win ? heap_rd_reg : best_l;
    assign best_idx  = right_win ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0];

    always_comb begin
        case (cmd.rd_sel)
            RD_SLOT:   rd_addr = pos_rd_reg[SLOT_W-1:0];
            RD_PARENT: rd_addr = parent;
            RD_LEFT:   rd_addr = l_idx[SLOT_W-1:0];
            RD_RIGHT:  rd_addr = r_idx[SLOT_W-1:0];
            RD_LAST:   rd_addr = cnt_reg[SLOT_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        case (cmd.heap_wsel)
            HW_RD:   heap_wdata = heap_rd_reg;
            HW_BEST: heap_wdata = best_e;
            default: heap_wdata = cur_reg;
        endcase
    end

    always_comb begin
        case (cmd.pos_wsel)
            PW_CLEAR: begin
                pos_waddr = clr_reg;
                pos_wdata = '0;
            end
            PW_INVAL_TOP: begin
                pos_waddr = heap_rd_reg.tid;
                pos_wdata = '0;
            end
            PW_INVAL_REQ: begin
                pos_waddr = tid_reg;
                pos_wdata = '0;
            end
            default: begin
                pos_waddr = heap_wdata.tid;
                pos_wdata = {1'b1, hole_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        heap_rd_reg <= heap_mem[rd_addr];
        if (cmd.heap_we) begin
            heap_mem[hole_reg] <= heap_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        pos_rd_reg <= pos_mem[tid_reg];
        if (cmd.pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
    end

    always_comb begin
        case (cmd.cur_op)
            CO_REQ:  cur_next = '{user: user_reg, tid: tid_reg, prio: prio_reg};
            CO_EDIT: cur_next = '{user: heap_rd_reg.user, tid: tid_reg, prio: prio_reg};
            CO_RD:   cur_next = heap_rd_reg;
            default: cur_next = cur_reg;
        endcase
    end

    always_comb begin
        case (cmd.hole_op)
            HO_CNT:    hole_next = cnt_reg[SLOT_W-1:0];
            HO_SLOT:   hole_next = pos_rd_reg[SLOT_W-1:0];
            HO_ZERO:   hole_next = '0;
            HO_PARENT: hole_next = parent;
            HO_BEST:   hole_next = best_idx;
            default:   hole_next = hole_reg;
        endcase
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            kind_reg <= req_kind_t'(s_req_type);
            user_reg <= s_user_id;
            tid_reg  <= s_task_id;
            prio_reg <= s_priority_req;
        end
        cur_reg  <= cur_next;
        hole_reg <= hole_next;
        if (cmd.left_ld) begin
            left_reg <= heap_rd_reg;
        end
        if (cmd.res_ld) begin
            res_status_reg <= cmd.res_status;
            res_user_reg   <= cmd.res_exec ? heap_rd_reg.user : '0;
            res_task_reg   <= cmd.res_exec ? heap_rd_reg.tid : '0;
        end
        if (cmd.out_ld) begin
            m_status_reg <= res_status_reg;
            m_user_reg   <= res_user_reg;
            m_task_reg   <= res_task_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + cnt_t'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - cnt_t'(1);
            end
            if (cmd.clr_inc) begin
                clr_reg <= clr_reg + tid_t'(1);
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.kind         = kind_reg;
    assign stat.pos_valid    = pos_rd_reg[SLOT_W];
    assign stat.cnt_zero     = cnt_reg == '0;
    assign stat.cnt_full     = cnt_reg == cnt_t'(HEAP_DEPTH);
    assign stat.hole_zero    = hole_reg == '0;
    assign stat.hole_is_last = {1'b0, hole_reg} == cnt_reg;
    assign stat.left_in      = l_idx < cnt_reg;
    assign stat.cur_wins     = outranks(cur_reg, heap_rd_reg);
    assign stat.best_is_cur  = !left_win && !right_win;
    assign stat.clr_done     = clr_reg == tid_t'(TASK_ID_COUNT - 1);
    assign stat.out_busy     = m_valid_reg && !m_ready;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_exec_user = m_user_reg;
    assign m_exec_task = m_task_reg;

endmodule

// ===== rtl/ihtq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed heap task queue controller
// Sequences clearing, request decode, sift up, sift down and result hand-off.
// ----------------------------------------------------------------------------
module ihtq_ctrl
    import ihtq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC1, S_DEC2, S_EDRD, S_DROP, S_DROPRD,
        S_RISE, S_RISEC, S_SINK, S_SINKL, S_SINKR, S_FINAL, S_RESP
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.pos_we   = 1'b1;
                cmd.pos_wsel = PW_CLEAR;
                cmd.clr_inc  = 1'b1;
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
                if (s_valid) begin
                    state_next = S_DEC1;
                end
            end
            S_DEC1: begin
                cmd.rd_sel = RD_ZERO;
                state_next = S_DEC2;
            end
            S_DEC2: begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
                if (stat.kind == REQ_EXEC) begin
                    if (stat.cnt_zero) begin
                        cmd.res_status = ST_EMPTY;
                    end else begin
                        cmd.res_exec = 1'b1;
                        cmd.pos_we   = 1'b1;
                        cmd.pos_wsel = PW_INVAL_TOP;
                        cmd.hole_op  = HO_ZERO;
                        cmd.cnt_dec  = 1'b1;
                        state_next   = S_DROP;
                    end
                end else if (stat.kind == REQ_ADD) begin
                    if (stat.pos_valid) begin
                        cmd.res_status = ST_DUP;
                    end else if (stat.cnt_full) begin
                        cmd.res_status = ST_FULL;
                    end else begin
                        cmd.cur_op  = CO_REQ;
                        cmd.hole_op = HO_CNT;
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_RISE;
                    end
                end else if (!stat.pos_valid) begin
                    cmd.res_status = ST_UNKNOWN;
                end else if (stat.kind == REQ_EDIT) begin
                    cmd.rd_sel  = RD_SLOT;
                    cmd.hole_op = HO_SLOT;
                    state_next  = S_EDRD;
                end else begin
                    cmd.pos_we   = 1'b1;
                    cmd.pos_wsel = PW_INVAL_REQ;
                    cmd.hole_op  = HO_SLOT;
                    cmd.cnt_dec  = 1'b1;
                    state_next   = S_DROP;
                end
            end
            S_EDRD: begin
                cmd.cur_op = CO_EDIT;
                state_next = S_RISE;
            end
            S_DROP: begin
                if (stat.hole_is_last) begin
                    state_next = S_RESP;
                end else begin
                    cmd.rd_sel = RD_LAST;
                    state_next = S_DROPRD;
                end
            end
            S_DROPRD: begin
                cmd.cur_op = CO_RD;
                state_next = S_RISE;
            end
            S_RISE: begin
                if (stat.hole_zero) begin
                    state_next = S_SINK;
                end else begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_RISEC;
                end
            end
            S_RISEC: begin
                if (stat.cur_wins) begin
                    cmd.heap_we   = 1'b1;
                    cmd.heap_wsel = HW_RD;
                    cmd.pos_we    = 1'b1;
                    cmd.pos_wsel  = PW_MOVE;
                    cmd.hole_op   = HO_PARENT;
                    state_next    = S_RISE;
                end else begin
                    state_next = S_SINK;
                end
            end
            S_SINK: begin
                if (stat.left_in) begin
                    cmd.rd_sel = RD_LEFT;
                    state_next = S_SINKL;
                end else begin
                    state_next = S_FINAL;
                end
            end
            S_SINKL: begin
                cmd.left_ld = 1'b1;
                cmd.rd_sel  = RD_RIGHT;
                state_next  = S_SINKR;
            end
            S_SINKR: begin
                if (stat.best_is_cur) begin
                    state_next = S_FINAL;
                end else begin
                    cmd.heap_we   = 1'b1;
                    cmd.heap_wsel = HW_BEST;
                    cmd.pos_we    = 1'b1;
                    cmd.pos_wsel  = PW_MOVE;
                    cmd.hole_op   = HO_BEST;
                    state_next    = S_SINK;
                end
            end
            S_FINAL: begin
                cmd.heap_we   = 1'b1;
                cmd.heap_wsel = HW_CUR;
                cmd.pos_we    = 1'b1;
                cmd.pos_wsel  = PW_MOVE;
                state_next    = S_RESP;
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
